// ===== hdl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types and constants for the page frame buffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int ROWS        = 64;
    localparam int COLUMNS     = 128;
    localparam int PAGES       = ROWS / 8;
    localparam int DEPTH       = PAGES * COLUMNS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] MODE_SET    = 4'd0;
    localparam logic [3:0] MODE_CLEAR  = 4'd1;
    localparam logic [3:0] MODE_LINE   = 4'd2;
    localparam logic [3:0] MODE_RECT   = 4'd3;
    localparam logic [3:0] MODE_FILL   = 4'd4;
    localparam logic [3:0] MODE_ROT_R  = 4'd5;
    localparam logic [3:0] MODE_ROT_L  = 4'd6;
    localparam logic [3:0] MODE_SETALL = 4'd7;
    localparam logic [3:0] MODE_CLRALL = 4'd8;
    localparam logic [3:0] MODE_READ   = 4'd9;

    typedef struct packed {
        logic [3:0] mode;
        logic [5:0] row_a;
        logic [6:0] col_a;
        logic [5:0] row_b;
        logic [6:0] col_b;
        logic [2:0] page_sel;
        logic       bad;
    } cmd_t;

endpackage

// ===== hdl/pfde_front.sv =====
// ----------------------------------------------------------------------------
// pfde_front
// Command intake: classify modes and queue commands for the back end.
// ----------------------------------------------------------------------------
module pfde_front
    import pfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [32:0] s_tdata,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_cmd.mode     = s_tdata[3:0];
        in_cmd.row_a    = s_tdata[9:4];
        in_cmd.col_a    = s_tdata[16:10];
        in_cmd.row_b    = s_tdata[22:17];
        in_cmd.col_b    = s_tdata[29:23];
        in_cmd.page_sel = s_tdata[32:30];
        in_cmd.bad      = (s_tdata[3:0] > MODE_READ);
    end

    assign s_tready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid while empty");
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("count not advanced");

endmodule

// ===== hdl/pfde_back.sv =====
// ----------------------------------------------------------------------------
// pfde_back
// Command executor: frame store, sweeps, Bresenham stepping, result register.
// ----------------------------------------------------------------------------
module pfde_back
    import pfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  cmd_t       q_cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [8:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_PIX_RD, ST_PIX_WR, ST_LINE_SETUP, ST_LINE_STEP,
        ST_FILL, ST_SWEEP, ST_ROT_RD, ST_ROT_WR, ST_READ, ST_DONE
    } state_t;

    logic [7:0] store [DEPTH];

    state_t              state_reg,  state_next;
    cmd_t                cmd_reg,    cmd_next;
    logic [ADDR_W:0]     sweep_reg,  sweep_next;
    logic [7:0]          fillv_reg,  fillv_next;
    logic signed [8:0]   r_reg,  r_next;
    logic signed [8:0]   c_reg,  c_next;
    logic signed [8:0]   r1_reg, r1_next;
    logic signed [8:0]   c1_reg, c1_next;
    logic signed [8:0]   dr_reg, dr_next;
    logic signed [8:0]   dc_reg, dc_next;
    logic signed [9:0]   err_reg, err_next;
    logic [1:0]          seg_reg, seg_next;
    logic                clr_reg, clr_next;
    logic                cont_reg, cont_next;
    logic [7:0]          carry_reg, carry_next;
    logic [7:0]          rdata_reg;
    logic [7:0]          res_reg,  res_next;
    logic                stat_reg, stat_next;
    logic [7:0]          odata_reg, odata_next;
    logic                ostat_reg, ostat_next;
    logic                ov_reg,   ov_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [7:0]          wdata;
    logic [ADDR_W-1:0]   raddr;
    logic                pix_ok;
    logic [ADDR_W-1:0]   pix_addr;
    logic [7:0]          pix_mask;
    logic [ADDR_W-1:0]   rot_base;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
        rdata_reg <= store[raddr];
    end

    assign pix_ok   = (r_reg >= 0) && (r_reg < 9'(ROWS)) && (c_reg >= 0)
                      && (c_reg < 9'(COLUMNS));
    assign pix_addr = ADDR_W'({r_reg[8:3], c_reg[COL_W-1:0]});
    assign pix_mask = 8'(1) << r_reg[2:0];
    assign rot_base = ADDR_W'(cmd_reg.page_sel) << COL_W;
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {ostat_reg, odata_reg};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        sweep_next = sweep_reg;
        fillv_next = fillv_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        r1_next    = r1_reg;
        c1_next    = c1_reg;
        dr_next    = dr_reg;
        dc_next    = dc_reg;
        err_next   = err_reg;
        seg_next   = seg_reg;
        clr_next   = clr_reg;
        cont_next  = cont_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        odata_next = odata_reg;
        ostat_next = ostat_reg;
        ov_next    = ov_reg;
        we         = 1'b0;
        waddr      = pix_addr;
        wdata      = 8'h00;
        raddr      = pix_addr;
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                we         = 1'b1;
                waddr      = sweep_reg[ADDR_W-1:0];
                wdata      = 8'h00;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (ADDR_W+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next  = q_cmd;
                    res_next  = 8'h00;
                    stat_next = q_cmd.bad;
                    seg_next  = 2'd0;
                    cont_next = 1'b0;
                    clr_next  = 1'b0;
                    r_next    = 9'($unsigned(q_cmd.row_a));
                    c_next    = 9'($unsigned(q_cmd.col_a));
                    case (q_cmd.mode)
                        MODE_SET:    state_next = ST_PIX_RD;
                        MODE_CLEAR:
                        begin
                            clr_next   = 1'b1;
                            state_next = ST_PIX_RD;
                        end
                        MODE_LINE:
                        begin
                            r1_next    = 9'($unsigned(q_cmd.row_b));
                            c1_next    = 9'($unsigned(q_cmd.col_b));
                            state_next = ST_LINE_SETUP;
                        end
                        MODE_RECT:
                        begin
                            r1_next    = 9'($unsigned(q_cmd.row_a));
                            c1_next    = 9'($unsigned(q_cmd.col_b));
                            state_next = ST_LINE_SETUP;
                        end
                        MODE_FILL:
                        begin
                            if (q_cmd.row_b > q_cmd.row_a && q_cmd.col_b > q_cmd.col_a)
                            begin
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_ROT_R, MODE_ROT_L:
                        begin
                            sweep_next = '0;
                            if (32'(q_cmd.page_sel) < PAGES)
                            begin
                                state_next = ST_ROT_RD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        MODE_SETALL, MODE_CLRALL:
                        begin
                            sweep_next = '0;
                            fillv_next = (q_cmd.mode == MODE_SETALL) ? 8'hFF : 8'h00;
                            state_next = ST_SWEEP;
                        end
                        MODE_READ:
                        begin
                            sweep_next = '0;
                            if (32'(q_cmd.page_sel) < PAGES && 32'(q_cmd.col_a) < COLUMNS)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                raddr = pix_addr;
                if (pix_ok)
                begin
                    state_next = ST_PIX_WR;
                end
                else if (cont_reg)
                begin
                    state_next = (cmd_reg.mode == MODE_FILL) ? ST_FILL : ST_LINE_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PIX_WR:
            begin
                we    = 1'b1;
                waddr = pix_addr;
                wdata = clr_reg ? (rdata_reg & ~pix_mask) : (rdata_reg | pix_mask);
                if (cont_reg)
                begin
                    state_next = (cmd_reg.mode == MODE_FILL) ? ST_FILL : ST_LINE_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LINE_SETUP:
            begin
                dr_next  = (r1_reg > r_reg) ? r1_reg - r_reg : r_reg - r1_reg;
                dc_next  = (c1_reg > c_reg) ? c1_reg - c_reg : c_reg - c1_reg;
                if (dr_next > dc_next)
                begin
                    err_next = 10'(dr_next >>> 1);
                end
                else
                begin
                    err_next = -10'(dc_next >>> 1);
                end
                cont_next  = 1'b1;
                state_next = ST_PIX_RD;
                cont_next  = 1'b1;
                // first pixel drawn, then step
                sweep_next = '0;
            end
            ST_LINE_STEP:
            begin
                if (r_reg == r1_reg && c_reg == c1_reg)
                begin
                    if (cmd_reg.mode == MODE_RECT && seg_reg != 2'd3)
                    begin
                        seg_next = seg_reg + 2'd1;
                        case (seg_reg)
                            2'd0:
                            begin
                                r_next  = 9'($unsigned(cmd_reg.row_b));
                                c_next  = 9'($unsigned(cmd_reg.col_b));
                                r1_next = 9'($unsigned(cmd_reg.row_a));
                                c1_next = 9'($unsigned(cmd_reg.col_b));
                            end
                            2'd1:
                            begin
                                r_next  = 9'($unsigned(cmd_reg.row_b));
                                c_next  = 9'($unsigned(cmd_reg.col_b));
                                r1_next = 9'($unsigned(cmd_reg.row_b));
                                c1_next = 9'($unsigned(cmd_reg.col_a));
                            end
                            default:
                            begin
                                r_next  = 9'($unsigned(cmd_reg.row_a));
                                c_next  = 9'($unsigned(cmd_reg.col_a));
                                r1_next = 9'($unsigned(cmd_reg.row_b));
                                c1_next = 9'($unsigned(cmd_reg.col_a));
                            end
                        endcase
                        state_next = ST_LINE_SETUP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    err_next = err_reg;
                    if (err_reg > -10'(dr_reg))
                    begin
                        err_next = err_next - 10'(dc_reg);
                        r_next   = (r_reg < r1_reg) ? r_reg + 9'sd1 : r_reg - 9'sd1;
                    end
                    if (err_reg < 10'(dc_reg))
                    begin
                        err_next = err_next + 10'(dr_reg);
                        c_next   = (c_reg < c1_reg) ? c_reg + 9'sd1 : c_reg - 9'sd1;
                    end
                    state_next = ST_PIX_RD;
                end
            end
            ST_FILL:
            begin
                if (!cont_reg)
                begin
                    cont_next  = 1'b1;
                    state_next = ST_PIX_RD;
                end
                else if (c_reg + 9'sd1 < 9'($unsigned(cmd_reg.col_b)))
                begin
                    c_next     = c_reg + 9'sd1;
                    state_next = ST_PIX_RD;
                end
                else if (r_reg + 9'sd1 < 9'($unsigned(cmd_reg.row_b)))
                begin
                    r_next     = r_reg + 9'sd1;
                    c_next     = 9'($unsigned(cmd_reg.col_a));
                    state_next = ST_PIX_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                we         = 1'b1;
                waddr      = sweep_reg[ADDR_W-1:0];
                wdata      = fillv_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (ADDR_W+1)'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROT_RD:
            begin
                // prime carry with the wrap byte
                if (cmd_reg.mode == MODE_ROT_R)
                begin
                    raddr = rot_base | ADDR_W'(COLUMNS - 1);
                end
                else
                begin
                    raddr = rot_base;
                end
                if (sweep_reg == '0)
                begin
                    sweep_next = (ADDR_W+1)'(1);
                end
                else
                begin
                    carry_next = rdata_reg;
                    sweep_next = '0;
                    state_next = ST_ROT_WR;
                end
                if (sweep_reg != '0)
                begin
                    raddr = (cmd_reg.mode == MODE_ROT_R) ? rot_base
                            : (rot_base | ADDR_W'(COLUMNS - 1));
                end
            end
            ST_ROT_WR:
            begin
                // even phase reads, odd phase writes carry and takes new byte
                if (!sweep_reg[0])
                begin
                    if (cmd_reg.mode == MODE_ROT_R)
                    begin
                        raddr = rot_base | ADDR_W'(sweep_reg[COL_W:1]);
                    end
                    else
                    begin
                        raddr = rot_base | ADDR_W'(COLUMNS - 1 - 32'(sweep_reg[COL_W:1]));
                    end
                    sweep_next = sweep_reg + 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    if (cmd_reg.mode == MODE_ROT_R)
                    begin
                        waddr = rot_base | ADDR_W'(sweep_reg[COL_W:1]);
                    end
                    else
                    begin
                        waddr = rot_base | ADDR_W'(COLUMNS - 1 - 32'(sweep_reg[COL_W:1]));
                    end
                    wdata      = carry_reg;
                    carry_next = rdata_reg;
                    sweep_next = sweep_reg + 1'b1;
                    if (32'(sweep_reg[COL_W:1]) == COLUMNS - 1)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                raddr = ADDR_W'({cmd_reg.page_sel, cmd_reg.col_a});
                if (sweep_reg == '0)
                begin
                    sweep_next = (ADDR_W+1)'(1);
                end
                else
                begin
                    res_next   = rdata_reg;
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    odata_next = res_reg;
                    ostat_next = stat_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        fillv_reg <= fillv_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        r1_reg    <= r1_next;
        c1_reg    <= c1_next;
        dr_reg    <= dr_next;
        dc_reg    <= dc_next;
        err_reg   <= err_next;
        seg_reg   <= seg_next;
        clr_reg   <= clr_next;
        cont_reg  <= cont_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        odata_reg <= odata_next;
        ostat_reg <= ostat_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_init_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !q_ready) else $error("took command in init");
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ostat_reg) |-> (odata_reg == 8'h00)) else $error("bad status data");

endmodule

// ===== hdl/page_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page frame store with pixel, line, rectangle and page commands.
//
// s_* carries one command per request; m_* returns one result per command.
// A two-entry queue sits in front of the executor, so commands may be
// offered while one is still running. Pixel set/clear reads and then writes
// the byte that holds the pixel, a line is drawn one pixel at a time after
// setup, a filled rectangle visits each pixel of its area in turn, rotate
// reads and rewrites every byte of the page, set/clear all writes every
// byte of the store, and read byte reads one byte.
// After reset a clearing pass zeroes all DEPTH (1024) bytes of the store
// while no command is taken. A stalled receiver holds the result in the
// output register; the executor then waits before its next result.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine
    import pfde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, row_a, col_a, row_b, col_b, page_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data, status
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;
    logic [8:0] res;

    pfde_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata[32:0]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    pfde_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (res)
    );

    assign m_tdata = {7'd0, res};

endmodule
